/* rtl/dmsc_pkg.sv */
`default_nettype none
package dmsc_pkg;

	localparam int unsigned CMD_W = 3;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned LEVEL_W = 7;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned LEN_W = 12;
	localparam int unsigned BITS_W = 4;

	localparam logic [ADDR_W-1:0] WRAP_ADDR = 16'h8000;
	localparam logic [LEVEL_W-1:0] LEVEL_TOP = 7'd125;
	localparam logic [LEVEL_W-1:0] LEVEL_STEP = 7'd2;
	localparam logic [BITS_W-1:0] BYTE_BITS = 4'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_CONTROL = 3'd1,
		CMD_LEVEL   = 3'd2,
		CMD_START   = 3'd3,
		CMD_LENGTH  = 3'd4,
		CMD_ENABLE  = 3'd5
	} dmsc_cmd_t;

	typedef struct packed {
		logic                enable_flag;
		logic [LEVEL_W-1:0]  out_level;
		logic [ADDR_W-1:0]   start_address;
		logic [LEN_W-1:0]    start_length;
		logic [ADDR_W-1:0]   read_address;
		logic [LEN_W-1:0]    bytes_left;
		logic [DATA_W-1:0]   shift_bits;
		logic [BITS_W-1:0]   bits_left;
		logic [DATA_W-1:0]   tick_count;
		logic [DATA_W-1:0]   tick_reload;
		logic                loop_flag;
	} dmsc_state_t;

	function automatic logic [DATA_W-1:0] rate_period(input logic [3:0] idx);
		logic [DATA_W-1:0] p;
		case (idx)
			4'd0:    p = 8'd214;
			4'd1:    p = 8'd190;
			4'd2:    p = 8'd170;
			4'd3:    p = 8'd160;
			4'd4:    p = 8'd143;
			4'd5:    p = 8'd127;
			4'd6:    p = 8'd113;
			4'd7:    p = 8'd107;
			4'd8:    p = 8'd95;
			4'd9:    p = 8'd80;
			4'd10:   p = 8'd71;
			4'd11:   p = 8'd64;
			4'd12:   p = 8'd53;
			4'd13:   p = 8'd42;
			4'd14:   p = 8'd36;
			default: p = 8'd27;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

/* rtl/dmsc_step.sv */
`default_nettype none
module dmsc_step
	import dmsc_pkg::*;
(
	input  dmsc_state_t       cur,
	input  logic [CMD_W-1:0]  command,
	input  logic [DATA_W-1:0] write_data,
	input  logic [DATA_W-1:0] fetched_byte,
	output dmsc_state_t       nxt,
	output logic              fetch_taken
);

	dmsc_state_t f;
	logic        do_fetch;

	// fetch phase of a tick
	always_comb begin
		f = cur;
		do_fetch = (cur.bytes_left != '0) && (cur.bits_left == '0);
		if (do_fetch) begin
			f.shift_bits = fetched_byte;
			f.bits_left = BYTE_BITS;
			f.read_address = (cur.read_address == '1) ? WRAP_ADDR : cur.read_address + 1'b1;
			f.bytes_left = cur.bytes_left - 1'b1;
			if ((f.bytes_left == '0) && cur.loop_flag) begin
				f.read_address = cur.start_address;
				f.bytes_left = cur.start_length;
			end
		end
	end

	always_comb begin
		nxt = cur;
		fetch_taken = 1'b0;
		unique case (dmsc_cmd_t'(command))
			CMD_TICK: begin
				if (cur.enable_flag) begin
					nxt = f;
					fetch_taken = do_fetch;
					if (f.tick_count == '0) begin
						nxt.tick_count = f.tick_reload;
						if (f.bits_left != '0) begin
							if (f.shift_bits[0]) begin
								if (f.out_level <= LEVEL_TOP)
									nxt.out_level = f.out_level + LEVEL_STEP;
							end else if (f.out_level >= LEVEL_STEP) begin
								nxt.out_level = f.out_level - LEVEL_STEP;
							end
							nxt.shift_bits = f.shift_bits >> 1;
							nxt.bits_left = f.bits_left - 1'b1;
						end
					end else begin
						nxt.tick_count = f.tick_count - 1'b1;
					end
				end
			end
			CMD_CONTROL: begin
				nxt.loop_flag = write_data[6];
				nxt.tick_reload = rate_period(write_data[3:0]);
			end
			CMD_LEVEL: begin
				nxt.out_level = write_data[LEVEL_W-1:0];
			end
			CMD_START: begin
				nxt.start_address = {2'b11, write_data, 6'b000000};
			end
			CMD_LENGTH: begin
				nxt.start_length = {write_data, 4'b0001};
			end
			CMD_ENABLE: begin
				nxt.enable_flag = write_data[0];
				if (!write_data[0]) begin
					nxt.bytes_left = '0;
				end else if (cur.bytes_left == '0) begin
					nxt.read_address = cur.start_address;
					nxt.bytes_left = cur.start_length;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/delta_modulation_sample_channel.sv */
// An item accepted from s_tdata is held in the input register, then its result
// is registered onto m_tdata with m_tvalid.
// Throughput: one item per cycle unless m_tready stalls the output; input
// register and result register each advance whenever the next stage is free,
// so output stalls back up only once both are full.
// Reset (arst_n low, asynchronous): all channel state and both valids clear.
`default_nettype none
module delta_modulation_sample_channel
	import dmsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // write_data[7:0], fetched_byte[15:8]
	input  wire logic [2:0]  s_tuser,  // command[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata   // level[6:0], fetch_address[22:7], fetch_taken[23]
);

	logic              in_v_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [DATA_W-1:0] data_s1;
	logic [DATA_W-1:0] byte_s1;
	dmsc_state_t       state_q;
	dmsc_state_t       state_nxt;
	logic              taken;
	logic              advance;

	assign advance = in_v_s1 && (!m_tvalid || m_tready);
	assign s_tready = !in_v_s1 || advance;

	dmsc_step u_step (
		.cur          (state_q),
		.command      (cmd_s1),
		.write_data   (data_s1),
		.fetched_byte (byte_s1),
		.nxt          (state_nxt),
		.fetch_taken  (taken)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
			m_tvalid <= 1'b0;
			state_q <= '0;
		end else begin
			if (s_tvalid && s_tready)
				in_v_s1 <= 1'b1;
			else if (advance)
				in_v_s1 <= 1'b0;
			if (advance) begin
				m_tvalid <= 1'b1;
				state_q <= state_nxt;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tuser;
			data_s1 <= s_tdata[7:0];
			byte_s1 <= s_tdata[15:8];
		end
		if (advance)
			m_tdata <= {taken, state_nxt.read_address, state_nxt.out_level};
	end

endmodule
`default_nettype wire
